FILE: rtl/track_card_slot_store_macros.svh
// Assertion macros for the card track slot store checker.
// Each macro clocks on clk_i and is disabled while rst_ni is low.
`ifndef TRACK_CARD_SLOT_STORE_MACROS_SVH
`define TRACK_CARD_SLOT_STORE_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define TCSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// A condition that must never be seen at a clock edge outside reset.
`define TCSS_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

FILE: rtl/tcss_pkg.sv
// Shared types, constants and helpers for the card track slot store.
// No dependencies; used by the top level and the checker.
`default_nettype none

package tcss_pkg;

  localparam int unsigned SLOT_COUNT_DEF     = 26;
  localparam int unsigned BYTES_PER_SLOT_DEF = 20;

  localparam int unsigned CMD_W  = 2;
  localparam int unsigned SLOT_W = 5;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned NIB_W  = 6;
  localparam int unsigned CODE_W = 4;

  // Hard cap on nibbles written to or scanned in one slot.
  localparam int unsigned MAX_NIBBLES = 40;

  localparam logic [CODE_W-1:0] SENTINEL  = 4'hF;
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_LAST = 8'h3F;
  localparam logic [CHAR_W-1:0] CHAR_MAXOUT = 8'h3E;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_END   = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FINISH,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMPTY
  } state_e;

  // Characters outside '0'..'?' are stored as code zero.
  function automatic logic [CODE_W-1:0] char_to_code(logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] diff;
    diff = c - CHAR_ZERO;
    if (c >= CHAR_ZERO && c <= CHAR_LAST) begin
      return diff[CODE_W-1:0];
    end
    return '0;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/tcss_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module tcss_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 2,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/track_card_slot_store.sv
// Card track slot store: a write character is taken while idle; ending a session
// pads or clears up to BYTES_PER_SLOT bytes of the slot. A read scans one byte per
// probe (a read, then a check state), then emits each character through a read
// and a load state when the output side is ready, as the single memory read port
// demands. After reset the store, SLOT_COUNT * BYTES_PER_SLOT bytes (520 by
// default), is swept to zero, one byte a cycle; no word is taken meanwhile.
`default_nettype none

module track_card_slot_store #(
  parameter int unsigned SLOT_COUNT     = tcss_pkg::SLOT_COUNT_DEF,
  parameter int unsigned BYTES_PER_SLOT = tcss_pkg::BYTES_PER_SLOT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tcss_pkg::CMD_W-1:0]    cmd_i,
  input  logic [tcss_pkg::SLOT_W-1:0]   slot_i,
  input  logic [tcss_pkg::CHAR_W-1:0]   char_code_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tcss_pkg::CHAR_W-1:0]   character_o,
  output logic [tcss_pkg::NIB_W-1:0]    char_index_o,
  output logic                          last_o,
  output logic                          empty_res_o
);

  import tcss_pkg::*;

  localparam int unsigned DEPTH     = SLOT_COUNT * BYTES_PER_SLOT;
  localparam int unsigned ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NIB_LIMIT = (2 * BYTES_PER_SLOT < MAX_NIBBLES) ?
                                      2 * BYTES_PER_SLOT : MAX_NIBBLES;
  localparam int unsigned CMP_W     = NIB_W + 1;

  // Byte address of an offset within a slot. The product stays below DEPTH
  // for any valid slot, so arithmetic modulo 2**ADDR_W is exact.
  function automatic logic [ADDR_W-1:0] addr_of(logic [SLOT_W-1:0] s,
                                                logic [NIB_W-1:0]  off);
    return ADDR_W'(s) * ADDR_W'(BYTES_PER_SLOT) + ADDR_W'(off);
  endfunction

  state_e state_q, state_d;

  // Write session state.
  logic [NIB_W-1:0]  cnt_q, cnt_d;
  logic [CODE_W-1:0] pend_q, pend_d;
  logic [SLOT_W-1:0] sess_slot_q, sess_slot_d;
  logic              sess_open_q, sess_open_d;

  // Sweep and session finish state.
  logic [ADDR_W-1:0] clr_addr_q, clr_addr_d;
  logic [SLOT_W-1:0] fin_slot_q, fin_slot_d;
  logic [NIB_W-1:0]  ptr_q, ptr_d;
  logic [CODE_W-1:0] pad_q, pad_d;

  // Read state. During the scan nib_q steps by two (one byte per probe);
  // during emission it steps by one nibble.
  logic [SLOT_W-1:0] rd_slot_q, rd_slot_d;
  logic [NIB_W-1:0]  nib_q, nib_d;
  logic [NIB_W-1:0]  len_q, len_d;

  // Output register.
  logic              out_valid_q, out_valid_d;
  logic [CHAR_W-1:0] out_char_q, out_char_d;
  logic [NIB_W-1:0]  out_idx_q, out_idx_d;
  logic              out_last_q, out_last_d;
  logic              out_empty_q, out_empty_d;

  // Memory ports.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CHAR_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CHAR_W-1:0] ram_rdata;

  // Decode of the word at the input.
  logic              accept;
  logic              out_free;
  logic              slot_ok;
  logic [CODE_W-1:0] code;
  logic [NIB_W-1:0]  wr_cnt;
  logic              wr_take;
  logic              wr_room;
  logic [NIB_W-1:0]  fin_start;
  logic              fin_go;
  logic              fin_fits;
  logic [CODE_W-1:0] rd_lo;
  logic [CODE_W-1:0] rd_hi;
  logic [CODE_W-1:0] rd_nib;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign slot_ok    = {1'b0, slot_i} < (SLOT_W + 1)'(SLOT_COUNT);
  assign code       = char_to_code(char_code_i);

  // A write with no open session starts one at count zero.
  assign wr_cnt  = sess_open_q ? cnt_q : '0;
  assign wr_take = accept && (cmd_e'(cmd_i) == CMD_WRITE) && (sess_open_q || slot_ok);
  assign wr_room = wr_cnt < NIB_W'(NIB_LIMIT);

  // Ending a session starts at the byte holding an odd last nibble, or at the
  // first unused byte; a full slot needs no finishing pass at all.
  assign fin_start = {1'b0, wr_cnt[NIB_W-1:1]};
  assign fin_go    = sess_open_q || slot_ok;
  assign fin_fits  = CMP_W'(fin_start) < CMP_W'(BYTES_PER_SLOT);

  assign rd_lo  = ram_rdata[CODE_W-1:0];
  assign rd_hi  = ram_rdata[2*CODE_W-1:CODE_W];
  assign rd_nib = nib_q[0] ? rd_hi : rd_lo;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd_e'(cmd_i))
            CMD_END: begin
              if (fin_go && fin_fits) begin
                state_d = ST_FINISH;
              end
            end
            CMD_READ: begin
              state_d = slot_ok ? ST_SCAN_RD : ST_EMPTY;
            end
            CMD_WRITE, CMD_NOP: begin
              state_d = ST_IDLE;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_FINISH: begin
        if (ptr_q == NIB_W'(BYTES_PER_SLOT - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN_RD: begin
        state_d = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        if (rd_lo == SENTINEL) begin
          state_d = (nib_q == '0) ? ST_EMPTY : ST_EMIT_RD;
        end else if (rd_hi == SENTINEL) begin
          state_d = ST_EMIT_RD;
        end else if (nib_q == NIB_W'(NIB_LIMIT - 2)) begin
          state_d = ST_EMPTY;
        end else begin
          state_d = ST_SCAN_RD;
        end
      end
      ST_EMIT_RD: begin
        state_d = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        if (out_free) begin
          state_d = (nib_q + 1'b1 == len_q) ? ST_IDLE : ST_EMIT_RD;
        end
      end
      ST_EMPTY: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Datapath, memory controls and output register loads.
  always_comb begin
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    sess_slot_d = sess_slot_q;
    sess_open_d = sess_open_q;
    clr_addr_d  = clr_addr_q;
    fin_slot_d  = fin_slot_q;
    ptr_d       = ptr_q;
    pad_d       = pad_q;
    rd_slot_d   = rd_slot_q;
    nib_d       = nib_q;
    len_d       = len_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_char_d  = out_char_q;
    out_idx_d   = out_idx_q;
    out_last_d  = out_last_q;
    out_empty_d = out_empty_q;
    ram_we      = 1'b0;
    ram_waddr   = addr_of(sess_slot_q, {1'b0, cnt_q[NIB_W-1:1]});
    ram_wdata   = {code, pend_q};
    ram_raddr   = addr_of(rd_slot_q, {1'b0, nib_q[NIB_W-1:1]});

    unique case (state_q)
      ST_CLEAR: begin
        ram_we     = 1'b1;
        ram_waddr  = clr_addr_q;
        ram_wdata  = '0;
        clr_addr_d = clr_addr_q + 1'b1;
      end
      ST_IDLE: begin
        if (wr_take) begin
          if (!sess_open_q) begin
            sess_open_d = 1'b1;
            sess_slot_d = slot_i;
            cnt_d       = '0;
            pend_d      = '0;
          end
          if (wr_room) begin
            cnt_d = wr_cnt + 1'b1;
            if (wr_cnt[0]) begin
              // Odd nibble completes a byte; the session is already open here.
              ram_we = 1'b1;
            end else begin
              pend_d = code;
            end
          end
        end
        if (accept && (cmd_e'(cmd_i) == CMD_END)) begin
          fin_slot_d  = sess_open_q ? sess_slot_q : slot_i;
          ptr_d       = fin_start;
          pad_d       = wr_cnt[0] ? pend_q : '0;
          sess_open_d = 1'b0;
          cnt_d       = '0;
          pend_d      = '0;
        end
        if (accept && (cmd_e'(cmd_i) == CMD_READ)) begin
          rd_slot_d = slot_i;
          nib_d     = '0;
        end
      end
      ST_FINISH: begin
        ram_we    = 1'b1;
        ram_waddr = addr_of(fin_slot_q, ptr_q);
        ram_wdata = {{CODE_W{1'b0}}, pad_q};
        pad_d     = '0;
        ptr_d     = ptr_q + 1'b1;
      end
      ST_SCAN_RD: begin
      end
      ST_SCAN_CHK: begin
        if (rd_lo == SENTINEL) begin
          len_d = nib_q;
          nib_d = '0;
        end else if (rd_hi == SENTINEL) begin
          len_d = nib_q + 1'b1;
          nib_d = '0;
        end else begin
          nib_d = nib_q + NIB_W'(2);
        end
      end
      ST_EMIT_RD: begin
      end
      ST_EMIT_LD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = CHAR_ZERO + CHAR_W'(rd_nib);
          out_idx_d   = nib_q;
          out_last_d  = (nib_q + 1'b1 == len_q);
          out_empty_d = 1'b0;
          nib_d       = nib_q + 1'b1;
        end
      end
      ST_EMPTY: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = '0;
          out_idx_d   = '0;
          out_last_d  = 1'b1;
          out_empty_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      cnt_q       <= '0;
      pend_q      <= '0;
      sess_slot_q <= '0;
      sess_open_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      sess_slot_q <= sess_slot_d;
      sess_open_q <= sess_open_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fin_slot_q  <= fin_slot_d;
    ptr_q       <= ptr_d;
    pad_q       <= pad_d;
    rd_slot_q   <= rd_slot_d;
    nib_q       <= nib_d;
    len_q       <= len_d;
    out_char_q  <= out_char_d;
    out_idx_q   <= out_idx_d;
    out_last_q  <= out_last_d;
    out_empty_q <= out_empty_d;
  end

  tcss_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (DEPTH),
    .ADDR_W(ADDR_W)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign out_valid_o  = out_valid_q;
  assign character_o  = out_char_q;
  assign char_index_o = out_idx_q;
  assign last_o       = out_last_q;
  assign empty_res_o  = out_empty_q;

endmodule

`default_nettype wire

FILE: rtl/tcss_checker.sv
// Port-level checker for the card track slot store, bound to the top level.
// Depends on tcss_pkg and the assertion macros header.
`include "track_card_slot_store_macros.svh"
`default_nettype none

module tcss_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_ready_o,
  input wire logic                          out_valid_o,
  input wire logic                          out_ready_i,
  input wire logic [tcss_pkg::CHAR_W-1:0]   character_o,
  input wire logic [tcss_pkg::NIB_W-1:0]    char_index_o,
  input wire logic                          last_o,
  input wire logic                          empty_res_o
);

  import tcss_pkg::*;

  // A stalled result word keeps its payload.
  `TCSS_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(character_o) && $stable(char_index_o) && $stable(last_o) && $stable(empty_res_o), "result word changed while stalled")

  // An empty result is a lone final word with zero character and index.
  `TCSS_ASSERT(a_empty_form, out_valid_o && empty_res_o |-> last_o && character_o == '0 && char_index_o == '0, "malformed empty result")

  // Characters read back lie in '0'..'>'; the sentinel is never emitted.
  `TCSS_ASSERT(a_char_range, out_valid_o && !empty_res_o |-> character_o >= CHAR_ZERO && character_o <= CHAR_MAXOUT, "character out of range")

  // While a read still has words to deliver, no new input word is taken.
  `TCSS_ASSERT_NEVER(a_busy_read, out_valid_o && !last_o && in_ready_o, "input ready during an unfinished read")

endmodule

bind track_card_slot_store tcss_checker u_tcss_checker (.*);

`default_nettype wire

FILE: dv/track_card_slot_store_tb.sv
// Testbench for the card track slot store: directed and random write sessions and reads.
// Needs tcss_pkg and track_card_slot_store; an in-bench store model predicts every read.
`default_nettype none

module track_card_slot_store_tb;
  import tcss_pkg::*;

  localparam int unsigned SLOTS = SLOT_COUNT_DEF;
  localparam int unsigned BYTES = BYTES_PER_SLOT_DEF;
  // A slot holds at most this many nibbles, both when written and when scanned.
  localparam int unsigned NIB_LIMIT = (2 * BYTES < MAX_NIBBLES) ? 2 * BYTES : MAX_NIBBLES;
  // Hard ceiling on the run, in time units.
  localparam longint unsigned RUN_LIMIT = 64'd20 * 64'd1_000_000;

  // One character that a read is expected to return.
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic [NIB_W-1:0]  idx;
    logic              last;
    logic              is_empty;
  } read_char_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [CMD_W-1:0]  cmd_i;
  logic [SLOT_W-1:0] slot_i;
  logic [CHAR_W-1:0] char_code_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [CHAR_W-1:0] character_o;
  logic [NIB_W-1:0]  char_index_o;
  logic              last_o;
  logic              empty_res_o;

  // Model of the store contents and of the open write session.
  logic [7:0]        card_bytes [SLOTS*BYTES];
  int unsigned       wr_nibbles;
  logic [CODE_W-1:0] low_nibble;
  logic [SLOT_W-1:0] sess_slot;
  bit                sess_open;

  // Characters still owed by the block, oldest first.
  read_char_t expected_chars[$];

  int unsigned words_sent;
  int unsigned error_count;
  bit          steady_input;

  track_card_slot_store dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .slot_i       (slot_i),
    .char_code_i  (char_code_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .character_o  (character_o),
    .char_index_o (char_index_o),
    .last_o       (last_o),
    .empty_res_o  (empty_res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Store model
  // ---------------------------------------------------------------------------

  // Byte writes outside the slot are dropped, as in the block.
  task automatic put_byte(input int unsigned slot, input int unsigned offset,
                          input logic [7:0] value);
    if (slot < SLOTS && offset < BYTES) begin
      card_bytes[slot * BYTES + offset] = value;
    end
  endtask

  function automatic logic [CODE_W-1:0] nibble_at(input int unsigned slot,
                                                  input int unsigned n);
    logic [7:0] b;
    b = card_bytes[slot * BYTES + n / 2];
    return (n % 2) ? b[7:4] : b[3:0];
  endfunction

  // Closing a slot pads an odd final nibble with zero and clears every byte
  // past the string.
  task automatic close_slot(input int unsigned slot, input int unsigned nibbles);
    if (nibbles % 2) begin
      put_byte(slot, nibbles / 2, {4'h0, low_nibble});
    end
    for (int unsigned i = (nibbles + 1) / 2; i < BYTES; i++) begin
      put_byte(slot, i, 8'h00);
    end
  endtask

  // Applies one accepted word to the model and queues the characters that a
  // read is owed.
  task automatic apply_word(input logic [CMD_W-1:0] c, input logic [SLOT_W-1:0] s,
                            input logic [CHAR_W-1:0] ch);
    logic [CODE_W-1:0] code;
    int unsigned       len;
    bit                found;
    read_char_t        r;
    code  = '0;
    len   = 0;
    found = 1'b0;
    case (c)
      CMD_WRITE: begin
        // The first write with a valid slot opens a session on that slot;
        // later writes ignore their slot field.
        if (!sess_open && s >= SLOTS) begin
          return;
        end
        if (!sess_open) begin
          sess_open  = 1'b1;
          sess_slot  = s;
          wr_nibbles = 0;
          low_nibble = '0;
        end
        if (wr_nibbles >= NIB_LIMIT) begin
          return;
        end
        if (ch >= CHAR_ZERO && ch <= CHAR_LAST) begin
          code = CODE_W'(ch - CHAR_ZERO);
        end
        if (wr_nibbles % 2 == 0) begin
          low_nibble = code;
        end else begin
          put_byte(sess_slot, wr_nibbles / 2, {code, low_nibble});
        end
        wr_nibbles++;
      end
      CMD_END: begin
        if (sess_open) begin
          close_slot(sess_slot, wr_nibbles);
        end else if (s < SLOTS) begin
          low_nibble = '0;
          close_slot(s, 0);
        end
        sess_open  = 1'b0;
        wr_nibbles = 0;
        low_nibble = '0;
      end
      CMD_READ: begin
        if (s < SLOTS) begin
          for (int unsigned n = 0; n < NIB_LIMIT && !found; n++) begin
            if (nibble_at(s, n) == SENTINEL) begin
              found = 1'b1;
              len   = n;
            end
          end
        end
        if (!found || len == 0) begin
          r.ch       = '0;
          r.idx      = '0;
          r.last     = 1'b1;
          r.is_empty = 1'b1;
          expected_chars.push_back(r);
        end else begin
          for (int unsigned n = 0; n < len; n++) begin
            r.ch       = CHAR_ZERO + nibble_at(s, n);
            r.idx      = NIB_W'(n);
            r.last     = (n + 1 == len);
            r.is_empty = 1'b0;
            expected_chars.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Handshake helpers
  // ---------------------------------------------------------------------------

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // Presents one word at a falling edge and returns at the rising edge that
  // accepts it. Valid stays high across back-to-back words.
  task automatic send_word(input logic [CMD_W-1:0] c, input logic [SLOT_W-1:0] s,
                           input logic [CHAR_W-1:0] ch);
    int unsigned gap;
    gap = steady_input ? 0 : pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd_i       <= c;
    slot_i      <= s;
    char_code_i <= ch;
    in_valid_i  <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    apply_word(c, s, ch);
    words_sent++;
  endtask

  // A track character, usually '0'..'>' and sometimes any byte at all.
  function automatic logic [CHAR_W-1:0] rand_track_char();
    if ($urandom_range(0, 9) < 8) begin
      return CHAR_ZERO + CHAR_W'($urandom_range(0, 14));
    end
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [SLOT_W-1:0] rand_slot_field();
    return SLOT_W'($urandom_range(0, 31));
  endfunction

  // The output side stalls at random, with occasional long stretches of
  // steady readiness.
  initial begin
    int unsigned stall;
    out_ready_i = 1'b0;
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_ready_i <= 1'b1;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 4))
        @(negedge clk_i);
    end
  end

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      error_count++;
    end
  endfunction

  // Every accepted result word is matched against the oldest expectation.
  initial begin
    read_char_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected result word: character %0h index %0d last %0b empty %0b",
                 character_o, char_index_o, last_o, empty_res_o);
          error_count++;
        end else begin
          want = expected_chars.pop_front();
          check_field("character", want.ch, character_o);
          check_field("char_index", 8'(want.idx), 8'(char_index_o));
          check_field("last", 8'(want.last), 8'(last_o));
          check_field("empty_res", 8'(want.is_empty), 8'(empty_res_o));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // The store comes out of reset empty: the first and last slots read as empty
  // results, and so do invalid ones. A write to an invalid slot with no session
  // open, and the no-op command, must leave no trace.
  task automatic test_after_reset();
    send_word(CMD_READ, 5'd0, 8'h00);
    send_word(CMD_READ, 5'd25, 8'h00);
    send_word(CMD_READ, 5'd31, 8'h00);
    send_word(CMD_WRITE, 5'd31, CHAR_ZERO);
    send_word(CMD_NOP, 5'd0, CHAR_LAST);
    send_word(CMD_READ, 5'd26, 8'hFF);
  endtask

  // The highest code and two invalid characters, which turn into '0'. The end
  // word names another slot, which a session ignores.
  task automatic test_char_codes();
    send_word(CMD_WRITE, 5'd25, CHAR_MAXOUT);
    send_word(CMD_WRITE, 5'd31, 8'h00);
    send_word(CMD_WRITE, 5'd0, 8'hFF);
    send_word(CMD_WRITE, 5'd7, CHAR_LAST);
    send_word(CMD_END, 5'd0, 8'h00);
    send_word(CMD_READ, 5'd25, 8'h00);
    send_word(CMD_READ, 5'd0, 8'h00);
  endtask

  // Reads in the middle of a session see only completed bytes, and the
  // session stays open across them.
  task automatic test_read_in_session();
    send_word(CMD_WRITE, 5'd3, CHAR_ZERO + 8'd5);
    send_word(CMD_READ, 5'd3, 8'h00);
    send_word(CMD_WRITE, 5'd20, CHAR_LAST);
    send_word(CMD_READ, 5'd3, 8'h00);
    send_word(CMD_END, 5'd31, 8'h00);
    send_word(CMD_READ, 5'd3, 8'h00);
  endtask

  // A string that starts with the sentinel reads as empty, and an end word
  // with no session clears a valid slot and ignores an invalid one.
  task automatic test_empty_strings();
    send_word(CMD_WRITE, 5'd0, CHAR_LAST);
    send_word(CMD_END, 5'd0, 8'h00);
    send_word(CMD_READ, 5'd0, 8'h00);
    send_word(CMD_END, 5'd25, 8'h00);
    send_word(CMD_END, 5'd30, 8'h00);
    send_word(CMD_READ, 5'd25, 8'h00);
  endtask

  // The longest string: 39 characters and the sentinel fill the slot, and the
  // characters after it are dropped.
  task automatic test_full_slot();
    logic [SLOT_W-1:0] slot;
    slot = SLOT_W'($urandom_range(0, SLOTS - 1));
    for (int i = 0; i < 39; i++) begin
      send_word(CMD_WRITE, (i == 0) ? slot : rand_slot_field(),
                CHAR_ZERO + CHAR_W'($urandom_range(0, 14)));
    end
    send_word(CMD_WRITE, rand_slot_field(), CHAR_LAST);
    repeat (3) send_word(CMD_WRITE, rand_slot_field(), rand_track_char());
    send_word(CMD_END, rand_slot_field(), 8'h00);
    send_word(CMD_READ, slot, 8'h00);
  endtask

  // Mostly complete sessions with random content and length, some of them
  // overlong, unterminated or never ended, mixed with random noise words.
  task automatic test_random_sessions(input int unsigned count);
    int unsigned       target;
    int unsigned       len;
    int unsigned       r;
    logic [SLOT_W-1:0] slot;
    target = words_sent + count;
    while (words_sent < target) begin
      steady_input = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 9) < 2) begin
        send_word(CMD_W'($urandom_range(0, 3)), rand_slot_field(),
                  CHAR_W'($urandom_range(0, 255)));
      end else begin
        slot = ($urandom_range(0, 7) == 0) ? SLOT_W'($urandom_range(SLOTS, 31))
                                           : SLOT_W'($urandom_range(0, SLOTS - 1));
        r = $urandom_range(0, 9);
        len = (r < 7) ? $urandom_range(0, 12) :
              (r < 9) ? $urandom_range(13, 39) : $urandom_range(40, 45);
        for (int unsigned i = 0; i < len; i++) begin
          send_word(CMD_WRITE, (i == 0) ? slot : rand_slot_field(), rand_track_char());
          if ($urandom_range(0, 19) == 0) begin
            send_word(CMD_READ, slot, rand_track_char());
          end
        end
        if ($urandom_range(0, 6) != 0) begin
          send_word(CMD_WRITE, (len == 0) ? slot : rand_slot_field(), CHAR_LAST);
        end
        if ($urandom_range(0, 9) != 0) begin
          send_word(CMD_END, rand_slot_field(), rand_track_char());
        end
        send_word(CMD_READ, ($urandom_range(0, 4) == 0) ? rand_slot_field() : slot,
                  rand_track_char());
      end
    end
    steady_input = 1'b0;
  endtask

  // Drops valid, waits for every owed result, then watches for strays.
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    cmd_i        = CMD_NOP;
    slot_i       = '0;
    char_code_i  = '0;
    words_sent   = 0;
    error_count  = 0;
    steady_input = 1'b0;
    sess_open    = 1'b0;
    sess_slot    = '0;
    wr_nibbles   = 0;
    low_nibble   = '0;
    foreach (card_bytes[i]) card_bytes[i] = 8'h00;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // The block sweeps its store after reset; send_word simply waits on ready.
    test_after_reset();
    test_char_codes();
    test_read_in_session();
    test_empty_strings();
    test_full_slot();
    test_random_sessions(30);
    drain_results();

    if (error_count == 0) begin
      $display("[track_card_slot_store] OK");
    end else begin
      $display("[track_card_slot_store] ERROR");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(RUN_LIMIT);
    $display("[track_card_slot_store] ERROR");
    $finish;
  end

endmodule

`default_nettype wire
